### sv/hsv2rgb_pkg.sv
package hsv2rgb_pkg;

    // hue fixed point: degrees * 2^HUE_FRAC_BITS
    localparam int HUE_FRAC_BITS = 6;
    localparam int HUE_W         = 15;
    localparam int CH_W          = 8;
    localparam int CH_MAX        = (1 << CH_W) - 1;

    // one 60-degree sector and a pair of sectors in hue units
    localparam int SEG    = 60 << HUE_FRAC_BITS;
    localparam int TWO_D  = 2 * SEG;
    localparam int NPAIR  = ((1 << HUE_W) - 1) / TWO_D + 1;
    localparam int PAIR_W = (NPAIR > 1) ? $clog2(NPAIR) : 1;
    localparam int REM_W  = $clog2(TWO_D);
    localparam int DEF_W  = $clog2(SEG + 1);

    // channel = floor(v * (255*D - s*deficit) / (255*D))
    localparam int FULL = CH_MAX * SEG;
    localparam int P_W  = CH_W + DEF_W;
    localparam int T_W  = $clog2(FULL + 1);
    localparam int N_W  = CH_W + T_W;

    // 255*D = 3825 * 2^(HUE_FRAC_BITS+2): shift off the power of two,
    // then divide by the odd part with an exact reciprocal
    localparam int DIV_SHIFT   = HUE_FRAC_BITS + 2;
    localparam int DIV_ODD     = CH_MAX * 15;
    localparam int M_W         = N_W - DIV_SHIFT;
    localparam int RECIP_SHIFT = M_W + $clog2(DIV_ODD);
    localparam longint unsigned RECIP =
        ((64'd1 << RECIP_SHIFT) + longint'(DIV_ODD) - 64'd1) / longint'(DIV_ODD);
    localparam int RECIP_W = $clog2(RECIP + 1);
    localparam int PROD_W  = M_W + RECIP_W;
    localparam int Q_W     = PROD_W - RECIP_SHIFT;

    // pipeline: two stages in the top level, four in each channel
    localparam int NSTG   = 6;
    localparam int CH_STG = 4;

    localparam int SECT_W = 3;

    typedef enum logic [SECT_W-1:0] {
        SECT_RED_YEL = 3'd0,
        SECT_YEL_GRN = 3'd1,
        SECT_GRN_CYA = 3'd2,
        SECT_CYA_BLU = 3'd3,
        SECT_BLU_MAG = 3'd4,
        SECT_MAG_RED = 3'd5
    } t_sector;

    typedef struct packed {
        logic [CH_STG-1:0] en;
    } t_chan_ctrl;

endpackage

### sv/hsv2rgb_chan.sv
module hsv2rgb_chan (
    input  logic                           i_clk,
    input  hsv2rgb_pkg::t_chan_ctrl        i_ctrl,
    input  logic [hsv2rgb_pkg::CH_W-1:0]   i_sat,
    input  logic [hsv2rgb_pkg::CH_W-1:0]   i_bri,
    input  logic [hsv2rgb_pkg::DEF_W-1:0]  i_def,
    output logic [hsv2rgb_pkg::CH_W-1:0]   o_chan
);

    logic [hsv2rgb_pkg::P_W-1:0]    r_p,   n_p;
    logic [hsv2rgb_pkg::CH_W-1:0]   r_bri2, r_bri3;
    logic [hsv2rgb_pkg::T_W-1:0]    r_t,   n_t;
    logic [hsv2rgb_pkg::M_W-1:0]    r_m;
    logic [hsv2rgb_pkg::N_W-1:0]    n_n;
    logic [hsv2rgb_pkg::PROD_W-1:0] prod;
    logic [hsv2rgb_pkg::Q_W-1:0]    quo;
    logic [hsv2rgb_pkg::CH_W-1:0]   r_y,   n_y;

    assign n_p  = hsv2rgb_pkg::P_W'(i_sat) * hsv2rgb_pkg::P_W'(i_def);
    assign n_t  = hsv2rgb_pkg::T_W'(hsv2rgb_pkg::FULL) - hsv2rgb_pkg::T_W'(r_p);
    assign n_n  = hsv2rgb_pkg::N_W'(r_bri3) * hsv2rgb_pkg::N_W'(r_t);
    // exact floor division by the odd part of 255*D
    assign prod = hsv2rgb_pkg::PROD_W'(r_m) * hsv2rgb_pkg::PROD_W'(hsv2rgb_pkg::RECIP);
    assign quo  = prod[hsv2rgb_pkg::PROD_W-1:hsv2rgb_pkg::RECIP_SHIFT];
    assign n_y  = (quo > hsv2rgb_pkg::Q_W'(hsv2rgb_pkg::CH_MAX)) ?
                  hsv2rgb_pkg::CH_W'(hsv2rgb_pkg::CH_MAX) : quo[hsv2rgb_pkg::CH_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_ctrl.en[0]) begin
            r_p    <= n_p;
            r_bri2 <= i_bri;
        end
        if (i_ctrl.en[1]) begin
            r_t    <= n_t;
            r_bri3 <= r_bri2;
        end
        if (i_ctrl.en[2]) begin
            r_m <= n_n[hsv2rgb_pkg::N_W-1:hsv2rgb_pkg::DIV_SHIFT];
        end
        if (i_ctrl.en[3]) begin
            r_y <= n_y;
        end
    end

    assign o_chan = r_y;

endmodule

### sv/hsv_to_rgb_pixel.sv
// HSV to RGB pixel converter. Takes hue (degrees * 64, 15 bits), saturation
// and value (8 bits each, 255 = 1.0) and returns 8-bit red, green and blue,
// truncated toward zero and saturated. A hue at or beyond 360 degrees is not
// wrapped and falls into the magenta-to-red sector. Throughput is one pixel
// per clock while the output is not stalled, through the six-stage pipeline:
// sector split, weight select, then per channel a saturation product, a
// subtract, a value product and a constant reciprocal divide. Backpressure
// stalls only the stages that are full, so bubbles are squeezed out while
// the output waits.
module hsv_to_rgb_pixel (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // hue[14:0], saturation[22:15], brightness[30:23], pad
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata   // red[7:0], green[15:8], blue[23:16]
);

    localparam int HW = hsv2rgb_pkg::HUE_W;
    localparam int CW = hsv2rgb_pkg::CH_W;

    logic [HW-1:0] in_hue;
    logic [CW-1:0] in_sat, in_bri;

    logic [hsv2rgb_pkg::NSTG-1:0] r_vld;
    logic [hsv2rgb_pkg::NSTG-1:0] en;

    // stage 0
    logic [hsv2rgb_pkg::PAIR_W-1:0] r_pair, n_pair;
    logic [hsv2rgb_pkg::REM_W-1:0]  r_rem,  n_rem;
    logic [HW-1:0]                  base;
    logic [CW-1:0]                  r_sat0, r_bri0;

    // stage 1
    logic                           odd;
    logic [hsv2rgb_pkg::PAIR_W:0]   sect_num;
    hsv2rgb_pkg::t_sector           sector;
    logic [hsv2rgb_pkg::DEF_W-1:0]  sec_dist;
    logic [hsv2rgb_pkg::DEF_W-1:0]  r_def_r, r_def_g, r_def_b;
    logic [hsv2rgb_pkg::DEF_W-1:0]  n_def_r, n_def_g, n_def_b;
    logic [CW-1:0]                  r_sat1, r_bri1;

    hsv2rgb_pkg::t_chan_ctrl        chan_ctrl;
    logic [CW-1:0]                  red, green, blue;

    localparam logic [hsv2rgb_pkg::DEF_W-1:0] DEF_FULL =
        hsv2rgb_pkg::DEF_W'(hsv2rgb_pkg::SEG);
    localparam logic [hsv2rgb_pkg::REM_W-1:0] REM_SEG =
        hsv2rgb_pkg::REM_W'(hsv2rgb_pkg::SEG);

    assign in_hue = s_axis_tdata[HW-1:0];
    assign in_sat = s_axis_tdata[HW+CW-1:HW];
    assign in_bri = s_axis_tdata[HW+2*CW-1:HW+CW];

    // a stage moves when it is empty or the one after it moves
    always_comb begin
        en[hsv2rgb_pkg::NSTG-1] = ~r_vld[hsv2rgb_pkg::NSTG-1] | m_axis_tready;
        for (int k = hsv2rgb_pkg::NSTG - 2; k >= 0; k--) begin
            en[k] = ~r_vld[k] | en[k+1];
        end
    end

    assign s_axis_tready = en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= s_axis_tvalid;
            end
            for (int k = 1; k < hsv2rgb_pkg::NSTG; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // stage 0: which pair of sectors, and hue mod 120 degrees
    always_comb begin
        n_pair = '0;
        base   = '0;
        for (int k = 1; k < hsv2rgb_pkg::NPAIR; k++) begin
            if (int'(in_hue) >= k * hsv2rgb_pkg::TWO_D) begin
                n_pair = hsv2rgb_pkg::PAIR_W'(k);
                base   = HW'(k * hsv2rgb_pkg::TWO_D);
            end
        end
        n_rem = hsv2rgb_pkg::REM_W'(in_hue - base);
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_pair <= n_pair;
            r_rem  <= n_rem;
            r_sat0 <= in_sat;
            r_bri0 <= in_bri;
        end
    end

    // stage 1: deficit of each channel against full weight D
    // chroma -> 0, secondary -> |r - D|, none -> D
    assign odd      = (r_rem >= REM_SEG);
    assign sec_dist = odd ? hsv2rgb_pkg::DEF_W'(r_rem - REM_SEG)
                          : hsv2rgb_pkg::DEF_W'(REM_SEG - r_rem);
    assign sect_num = {r_pair, odd};
    assign sector   = (sect_num >= (hsv2rgb_pkg::PAIR_W + 1)'(hsv2rgb_pkg::SECT_MAG_RED)) ?
                      hsv2rgb_pkg::SECT_MAG_RED :
                      hsv2rgb_pkg::t_sector'(sect_num[hsv2rgb_pkg::SECT_W-1:0]);

    always_comb begin
        unique case (sector)
            hsv2rgb_pkg::SECT_RED_YEL: begin
                n_def_r = '0;       n_def_g = sec_dist; n_def_b = DEF_FULL;
            end
            hsv2rgb_pkg::SECT_YEL_GRN: begin
                n_def_r = sec_dist; n_def_g = '0;       n_def_b = DEF_FULL;
            end
            hsv2rgb_pkg::SECT_GRN_CYA: begin
                n_def_r = DEF_FULL; n_def_g = '0;       n_def_b = sec_dist;
            end
            hsv2rgb_pkg::SECT_CYA_BLU: begin
                n_def_r = DEF_FULL; n_def_g = sec_dist; n_def_b = '0;
            end
            hsv2rgb_pkg::SECT_BLU_MAG: begin
                n_def_r = sec_dist; n_def_g = DEF_FULL; n_def_b = '0;
            end
            default: begin
                n_def_r = '0;       n_def_g = DEF_FULL; n_def_b = sec_dist;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r_def_r <= n_def_r;
            r_def_g <= n_def_g;
            r_def_b <= n_def_b;
            r_sat1  <= r_sat0;
            r_bri1  <= r_bri0;
        end
    end

    assign chan_ctrl.en = en[hsv2rgb_pkg::NSTG-1:2];

    hsv2rgb_chan u_chan_r (
        .i_clk  (i_clk),
        .i_ctrl (chan_ctrl),
        .i_sat  (r_sat1),
        .i_bri  (r_bri1),
        .i_def  (r_def_r),
        .o_chan (red)
    );

    hsv2rgb_chan u_chan_g (
        .i_clk  (i_clk),
        .i_ctrl (chan_ctrl),
        .i_sat  (r_sat1),
        .i_bri  (r_bri1),
        .i_def  (r_def_g),
        .o_chan (green)
    );

    hsv2rgb_chan u_chan_b (
        .i_clk  (i_clk),
        .i_ctrl (chan_ctrl),
        .i_sat  (r_sat1),
        .i_bri  (r_bri1),
        .i_def  (r_def_b),
        .o_chan (blue)
    );

    assign m_axis_tvalid = r_vld[hsv2rgb_pkg::NSTG-1];
    assign m_axis_tdata  = {blue, green, red};

    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("pipeline not empty after reset");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (&r_vld) && !m_axis_tready)
        else $error("input stalled while a stage is empty");

    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[0] |-> int'(r_rem) < hsv2rgb_pkg::TWO_D)
        else $error("hue remainder out of range");

    a_def_roles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[1] |-> (r_def_r == '0 || r_def_g == '0 || r_def_b == '0) &&
                     (r_def_r == DEF_FULL || r_def_g == DEF_FULL || r_def_b == DEF_FULL))
        else $error("no chroma or no empty channel in sector decode");

endmodule
